FILE: sv/csva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csva_pkg
// Shared constants, types and helper functions of the contiguous slot
// voice allocator.
// ----------------------------------------------------------------------------
package csva_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int MAX_OPS   = 6;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int RUN_W  = $clog2(NUM_SLOTS + 16);
    localparam int NOTE_W = 7;
    localparam int OPS_W  = 4;

    typedef logic [1:0] t_opcode;
    typedef logic [1:0] t_status;

    localparam t_opcode OP_NOTE_ON  = 2'd0;
    localparam t_opcode OP_NOTE_OFF = 2'd1;
    localparam t_opcode OP_ALL_OFF  = 2'd2;

    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_BAD_COUNT = 2'd1;
    localparam t_status ST_NO_RUN    = 2'd2;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [SLOT_W-1:0] base;
        logic [OPS_W-1:0]  size;
    } t_voice;

    typedef struct packed {
        logic    latch_in;
        logic    fit_calc;
        logic    alloc;
        logic    res_plain;
        t_status res_code;
        logic    scan_start;
        logic    scan_step;
        logic    all_off;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_opcode opcode;
        logic    count_bad;
        logic    total_zero;
        logic    found;
        logic    scan_last;
    } t_sts;

    function automatic logic [NUM_SLOTS-1:0] run_mask(input logic [SLOT_W-1:0] base,
                                                      input logic [OPS_W-1:0]  size);
        logic [NUM_SLOTS-1:0] m;
        logic [RUN_W-1:0]     lo;
        logic [RUN_W-1:0]     hi;
        lo = RUN_W'(base);
        hi = RUN_W'(base) + RUN_W'(size);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            m[i] = (RUN_W'(i) >= lo) && (RUN_W'(i) < hi);
        end
        return m;
    endfunction

    function automatic logic [31:0] mask32(input logic [NUM_SLOTS-1:0] m);
        logic [63:0] t;
        t = 64'(m);
        return t[31:0];
    endfunction

    function automatic logic [4:0] slot5(input logic [SLOT_W-1:0] v);
        logic [7:0] t;
        t = 8'(v);
        return t[4:0];
    endfunction

    function automatic logic [4:0] cnt5(input logic [CNT_W-1:0] v);
        logic [7:0] t;
        t = 8'(v);
        return t[4:0];
    endfunction

    function automatic logic [5:0] cnt6(input logic [CNT_W-1:0] v);
        logic [7:0] t;
        t = 8'(v);
        return t[5:0];
    endfunction

endpackage

FILE: sv/csva_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csva_in_if / csva_out_if
// Valid/ready channels for requests into and results out of the allocator.
// ----------------------------------------------------------------------------
interface csva_in_if;
    import csva_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [NOTE_W-1:0] note;
    logic [OPS_W-1:0]  op_count;

    modport source (output valid, output opcode, output note, output op_count, input ready);
    modport sink   (input valid, input opcode, input note, input op_count, output ready);
endinterface

interface csva_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  voice_index;
    logic [4:0]  first_slot;
    logic [31:0] key_on_mask;
    logic [31:0] key_off_mask;
    logic [5:0]  voices_left;

    modport source (output valid, output status, output voice_index, output first_slot,
                    output key_on_mask, output key_off_mask, output voices_left,
                    input ready);
    modport sink   (input valid, input status, input voice_index, input first_slot,
                    input key_on_mask, input key_off_mask, input voices_left,
                    output ready);
endinterface

FILE: sv/csva_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csva_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module csva_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/csva_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csva_ctrl
// Controller state machine: sequences decode, run search, table scan and
// result delivery, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module csva_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  csva_pkg::t_sts i_sts,
    output csva_pkg::t_cmd o_cmd
);
    import csva_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_ALLOC  = 5'b00100,
        S_SCAN   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch_in = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (i_sts.opcode)
                    OP_NOTE_ON: begin
                        if (i_sts.count_bad) begin
                            cmd.res_plain = 1'b1;
                            cmd.res_code  = ST_BAD_COUNT;
                        end else begin
                            cmd.fit_calc = 1'b1;
                            n_state      = S_ALLOC;
                        end
                    end
                    OP_NOTE_OFF: begin
                        if (i_sts.total_zero) begin
                            cmd.res_plain = 1'b1;
                            cmd.res_code  = ST_DONE;
                        end else begin
                            cmd.scan_start = 1'b1;
                            n_state        = S_SCAN;
                        end
                    end
                    OP_ALL_OFF: begin
                        cmd.all_off = 1'b1;
                    end
                    default: begin
                        cmd.res_plain = 1'b1;
                        cmd.res_code  = ST_DONE;
                    end
                endcase
            end
            S_ALLOC: begin
                n_state = S_DONE;
                if (i_sts.found) begin
                    cmd.alloc = 1'b1;
                end else begin
                    cmd.res_plain = 1'b1;
                    cmd.res_code  = ST_NO_RUN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
endmodule

FILE: sv/csva_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csva_dpath
// Datapath: slot occupancy row, first-fit run search, voice table with
// in-order compaction, and the result and output registers.
// ----------------------------------------------------------------------------
module csva_dpath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  csva_pkg::t_cmd            i_cmd,
    output csva_pkg::t_sts            o_sts,
    input  logic [1:0]                i_opcode,
    input  logic [csva_pkg::NOTE_W-1:0] i_note,
    input  logic [csva_pkg::OPS_W-1:0]  i_op_count,
    output logic [1:0]                o_status,
    output logic [4:0]                o_voice_index,
    output logic [4:0]                o_first_slot,
    output logic [31:0]               o_key_on_mask,
    output logic [31:0]               o_key_off_mask,
    output logic [5:0]                o_voices_left
);
    import csva_pkg::*;

    logic [1:0]           r_opcode;
    logic [NOTE_W-1:0]    r_note;
    logic [OPS_W-1:0]     r_count;
    logic [NUM_SLOTS-1:0] r_busy, n_busy;
    logic [CNT_W-1:0]     r_total, n_total;
    logic [NUM_SLOTS-1:0] r_fit;
    logic [CNT_W-1:0]     r_rd;
    logic [CNT_W-1:0]     r_wr;
    logic [NUM_SLOTS-1:0] r_off;

    logic [1:0]  r_res_status, n_res_status;
    logic [4:0]  r_res_vidx, n_res_vidx;
    logic [4:0]  r_res_base, n_res_base;
    logic [31:0] r_res_on, n_res_on;
    logic [31:0] r_res_off, n_res_off;
    logic [5:0]  r_res_left, n_res_left;

    logic [1:0]  r_out_status;
    logic [4:0]  r_out_vidx;
    logic [4:0]  r_out_base;
    logic [31:0] r_out_on;
    logic [31:0] r_out_off;
    logic [5:0]  r_out_left;

    logic [NUM_SLOTS+MAX_OPS-1:0] pad;
    logic [MAX_OPS-1:0]           len_mask;
    logic [NUM_SLOTS-1:0]         fit;
    logic [SLOT_W-1:0]            base_sel;
    logic [NUM_SLOTS-1:0]         on_mask;
    logic                         found;
    t_voice                       rd_voice;
    t_voice                       wr_voice;
    logic                         hit;
    logic [NUM_SLOTS-1:0]         off_next;
    logic                         scan_last;
    logic                         ram_we;
    logic [SLOT_W-1:0]            ram_waddr;
    logic [SLOT_W-1:0]            ram_raddr;
    logic [CNT_W-1:0]             total_inc;
    logic [CNT_W-1:0]             wr_inc;

    // A window that runs past the end of the row sees padded busy bits.
    always_comb begin
        pad = {{MAX_OPS{1'b1}}, r_busy};
        for (int k = 0; k < MAX_OPS; k++) begin
            len_mask[k] = (OPS_W'(k) < r_count);
        end
        for (int s = 0; s < NUM_SLOTS; s++) begin
            fit[s] = ~|(pad[s +: MAX_OPS] & len_mask);
        end
    end

    always_comb begin
        base_sel = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_fit[i]) begin
                base_sel = SLOT_W'(i);
            end
        end
    end

    assign found     = (|r_fit) && (r_total < CNT_W'(NUM_SLOTS));
    assign on_mask   = run_mask(base_sel, r_count);
    assign total_inc = r_total + CNT_W'(1);
    assign wr_inc    = r_wr + CNT_W'(1);
    assign hit       = (rd_voice.note == r_note);
    assign off_next  = hit ? (r_off | run_mask(rd_voice.base, rd_voice.size)) : r_off;
    assign scan_last = (r_rd == r_total);

    always_comb begin
        wr_voice.note = r_note;
        wr_voice.base = base_sel;
        wr_voice.size = r_count;
        if (!i_cmd.alloc) begin
            wr_voice = rd_voice;
        end
    end

    assign ram_we    = i_cmd.alloc || (i_cmd.scan_step && !hit);
    assign ram_waddr = i_cmd.alloc ? r_total[SLOT_W-1:0] : r_wr[SLOT_W-1:0];
    assign ram_raddr = i_cmd.scan_start ? '0 : r_rd[SLOT_W-1:0];

    csva_ram #(
        .WIDTH ($bits(t_voice)),
        .DEPTH (NUM_SLOTS)
    ) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_voice),
        .i_raddr (ram_raddr),
        .o_rdata (rd_voice)
    );

    always_comb begin
        n_busy       = r_busy;
        n_total      = r_total;
        n_res_status = r_res_status;
        n_res_vidx   = r_res_vidx;
        n_res_base   = r_res_base;
        n_res_on     = r_res_on;
        n_res_off    = r_res_off;
        n_res_left   = r_res_left;
        if (i_cmd.res_plain) begin
            n_res_status = i_cmd.res_code;
            n_res_vidx   = '0;
            n_res_base   = '0;
            n_res_on     = '0;
            n_res_off    = '0;
            n_res_left   = cnt6(r_total);
        end
        if (i_cmd.alloc) begin
            n_busy       = r_busy | on_mask;
            n_total      = total_inc;
            n_res_status = ST_DONE;
            n_res_vidx   = cnt5(r_total);
            n_res_base   = slot5(base_sel);
            n_res_on     = mask32(on_mask);
            n_res_off    = '0;
            n_res_left   = cnt6(total_inc);
        end
        if (i_cmd.all_off) begin
            n_busy       = '0;
            n_total      = '0;
            n_res_status = ST_DONE;
            n_res_vidx   = '0;
            n_res_base   = '0;
            n_res_on     = '0;
            n_res_off    = mask32(r_busy);
            n_res_left   = '0;
        end
        if (i_cmd.scan_step && scan_last) begin
            n_busy       = r_busy & ~off_next;
            n_total      = hit ? r_wr : wr_inc;
            n_res_status = ST_DONE;
            n_res_vidx   = '0;
            n_res_base   = '0;
            n_res_on     = '0;
            n_res_off    = mask32(off_next);
            n_res_left   = cnt6(hit ? r_wr : wr_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= '0;
            r_total <= '0;
        end else begin
            r_busy  <= n_busy;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_opcode <= i_opcode;
            r_note   <= i_note;
            r_count  <= i_op_count;
        end
        if (i_cmd.fit_calc) begin
            r_fit <= fit;
        end
        if (i_cmd.scan_start) begin
            r_rd  <= CNT_W'(1);
            r_wr  <= '0;
            r_off <= '0;
        end else if (i_cmd.scan_step) begin
            r_rd  <= r_rd + CNT_W'(1);
            r_off <= off_next;
            if (!hit) begin
                r_wr <= wr_inc;
            end
        end
        r_res_status <= n_res_status;
        r_res_vidx   <= n_res_vidx;
        r_res_base   <= n_res_base;
        r_res_on     <= n_res_on;
        r_res_off    <= n_res_off;
        r_res_left   <= n_res_left;
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_vidx   <= r_res_vidx;
            r_out_base   <= r_res_base;
            r_out_on     <= r_res_on;
            r_out_off    <= r_res_off;
            r_out_left   <= r_res_left;
        end
    end

    assign o_sts.opcode     = r_opcode;
    assign o_sts.count_bad  = (r_count == '0) || (r_count > OPS_W'(MAX_OPS));
    assign o_sts.total_zero = (r_total == '0);
    assign o_sts.found      = found;
    assign o_sts.scan_last  = scan_last;

    assign o_status       = r_out_status;
    assign o_voice_index  = r_out_vidx;
    assign o_first_slot   = r_out_base;
    assign o_key_on_mask  = r_out_on;
    assign o_key_off_mask = r_out_off;
    assign o_voices_left  = r_out_left;
endmodule

FILE: sv/contiguous_slot_voice_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_slot_voice_allocator_unit
// First-fit contiguous slot voice allocator with an ordered voice table.
// ----------------------------------------------------------------------------
// Note on: latch, first-fit search in decode, allocation, delivery. Rejected
// counts, all off, the unused opcode and note off with no voices go from decode
// to delivery; other note offs read and compact the voice table RAM one entry
// per cycle. New requests wait until the last result is loaded. A result waiting
// in the output register holds back only the result after it, not its request.
// Synchronous reset frees all slots and empties the voice table at once.
module contiguous_slot_voice_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csva_in_if.sink     i_req,
    csva_out_if.source  o_rsp
);
    import csva_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    csva_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    csva_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (i_req.opcode),
        .i_note         (i_req.note),
        .i_op_count     (i_req.op_count),
        .o_status       (o_rsp.status),
        .o_voice_index  (o_rsp.voice_index),
        .o_first_slot   (o_rsp.first_slot),
        .o_key_on_mask  (o_rsp.key_on_mask),
        .o_key_off_mask (o_rsp.key_off_mask),
        .o_voices_left  (o_rsp.voices_left)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
endmodule
